// ----- hdl/lfsm_pkg.sv -----
`default_nettype none

package lfsm_pkg;

	// Default and limits for the longest pattern the window can hold.
	localparam int unsigned PATTERN_MAX_DEF = 32;
	localparam int unsigned PATTERN_BYTES = 32;
	localparam int unsigned PATTERN_LEN_W = 6;
	localparam int unsigned LINE_NUM_W = 32;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;

	// Character codes used by the line splitter and the case folder.
	localparam logic [7:0] NEWLINE_CHAR = 8'd10;
	localparam logic [7:0] CHAR_UPPER_A = 8'd65;
	localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PATTERN_LENGTH = 3'd0,
		CFG_PATTERN_WORD_A = 3'd1,
		CFG_PATTERN_WORD_B = 3'd2,
		CFG_PATTERN_WORD_C = 3'd3,
		CFG_PATTERN_WORD_D = 3'd4,
		CFG_FOLD_CASE = 3'd5,
		CFG_INVERT_SELECT = 3'd6
	} cfg_reg_t;

	// Input word: one text byte or the end-of-stream marker.
	typedef struct packed {
		logic [7:0] text_byte;
		logic stream_end;
	} in_word_t;

	// Result word: one per newline or end marker.
	typedef struct packed {
		logic line_valid;
		logic [LINE_NUM_W-1:0] line_number;
		logic selected;
		logic stream_done;
		logic any_selected;
	} out_word_t;

	// What the word being processed does to the window and line state.
	typedef struct packed {
		logic shift;
		logic line_close;
		logic stream_end;
	} step_t;

	// Map A-Z to a-z when folding is on.
	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
		logic [7:0] r;
		r = b;
		if (fold && (b inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})) begin
			r = b + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/lfsm_window.sv -----
`default_nettype none

module lfsm_window import lfsm_pkg::*; #(
	parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
	localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1),
	localparam int unsigned PAT_BITS = PATTERN_MAX * 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire step_t step,
	input wire logic [7:0] text_byte,
	input wire logic [PAT_BITS-1:0] pattern,
	input wire logic [LEN_W-1:0] match_len,
	input wire logic fold_case,
	output logic byte_hit
);

	localparam int unsigned WIN_DEPTH = PATTERN_MAX - 1;
	localparam int unsigned FILL_W = $clog2(PATTERN_MAX);
	localparam int unsigned IDX_W = $clog2(PATTERN_MAX);

	logic [7:0] win_q [WIN_DEPTH];
	logic [FILL_W-1:0] fill_q;
	logic [7:0] cand [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] pos_eq;
	logic fill_ok;

	// Window of recent bytes of the line, newest at index 0.
	always_ff @(posedge clk) begin
		if (step.shift) begin
			win_q[0] <= text_byte;
			for (int k = 1; k < WIN_DEPTH; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

	// Count of window bytes that belong to the current line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (step.line_close) begin
			fill_q <= '0;
		end else if (step.shift && (fill_q != FILL_W'(WIN_DEPTH))) begin
			fill_q <= fill_q + FILL_W'(1);
		end
	end

	// Candidate bytes: the incoming byte followed by the window, folded.
	always_comb begin
		cand[0] = fold_byte(text_byte, fold_case);
		for (int k = 1; k < PATTERN_MAX; k++) begin
			cand[k] = fold_byte(win_q[k-1], fold_case);
		end
	end

	// Each position compares against the pattern byte aligned to its end.
	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pos
		logic [LEN_W-1:0] pidx;
		logic [7:0] pbyte;
		assign pidx = match_len - LEN_W'(j + 1);
		assign pbyte = fold_byte(pattern[{pidx[IDX_W-1:0], 3'b000} +: 8], fold_case);
		assign pos_eq[j] = (LEN_W'(j) >= match_len) || (cand[j] == pbyte);
	end

	// A hit needs enough bytes of this line and every used position equal.
	assign fill_ok = ((LEN_W'(fill_q) + LEN_W'(1)) >= match_len);
	assign byte_hit = (match_len != '0) && fill_ok && (&pos_eq);

endmodule

`default_nettype wire

// ----- hdl/lfsm_line_ctrl.sv -----
`default_nettype none

module lfsm_line_ctrl import lfsm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire step_t step,
	input wire logic byte_hit,
	input wire logic len_zero,
	input wire logic invert_select,
	output out_word_t result
);

	logic line_hit_q;
	logic line_open_q;
	logic [LINE_NUM_W-1:0] count_q;
	logic found_q;
	logic report;
	logic sel;
	logic found_new;
	logic [LINE_NUM_W-1:0] count_inc;

	// Line outcome and the saturating line counter.
	always_comb begin
		report = !step.stream_end || line_open_q;
		sel = (line_hit_q || len_zero) ^ invert_select;
		count_inc = (&count_q) ? count_q : count_q + LINE_NUM_W'(1);
		found_new = found_q || (report && sel);
	end

	// Result word for a newline or an end marker.
	always_comb begin
		result.line_valid = report;
		result.line_number = report ? count_inc : '0;
		result.selected = report && sel;
		result.stream_done = step.stream_end;
		result.any_selected = found_new;
	end

	// Per-line and per-stream state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_hit_q <= 1'b0;
			line_open_q <= 1'b0;
			count_q <= '0;
			found_q <= 1'b0;
		end else if (step.line_close) begin
			line_hit_q <= 1'b0;
			line_open_q <= 1'b0;
			if (step.stream_end) begin
				count_q <= '0;
				found_q <= 1'b0;
			end else begin
				count_q <= count_inc;
				found_q <= found_new;
			end
		end else if (step.shift) begin
			line_open_q <= 1'b1;
			if (byte_hit) begin
				line_hit_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/line_fixed_string_matcher.sv -----
// Fixed-string line matcher.
// Text enters on the in channel one word per cycle: a byte, or the end-of-stream
// marker. A word is taken when in_valid is high and in_stall is low. Byte 10 closes
// a line and yields one result word on the out channel; the end marker yields one
// result word that reports any unterminated line and the stream's sticky flag.
// Other bytes yield nothing.
// The pattern and its options must be written on the cfg channel (cfg_ready is
// always high) only while the block is idle; the block does not enforce this.
// A taken word is processed from the input register once the result register can
// take a word, and its result is written to the output register. One word is
// processed per cycle while the result register is not held; the window compare
// against all pattern positions runs in parallel in the single processing stage.
// When the receiver stalls, the result word holds; the input register still takes
// one more word, and in_stall rises only when that word has nowhere to go.
// Reset clears the configuration, the line state and both handshake registers.
`default_nettype none

module line_fixed_string_matcher import lfsm_pkg::*; #(
	parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire in_word_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output out_word_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int unsigned PAT_BITS = PATTERN_MAX * 8;

	logic [PATTERN_LEN_W-1:0] pattern_length_q;
	logic [CFG_DATA_W-1:0] pattern_word_q [4];
	logic fold_case_q;
	logic invert_select_q;
	logic [PATTERN_BYTES*8-1:0] pattern_all;
	logic [LEN_W-1:0] match_len;

	in_word_t in_s1;
	logic in_valid_s1;
	logic advance;
	logic proc;
	logic is_newline;
	step_t step;
	logic byte_hit;
	out_word_t result;
	out_word_t out_q;
	logic out_valid_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= '0;
			for (int i = 0; i < 4; i++) begin
				pattern_word_q[i] <= '0;
			end
			fold_case_q <= 1'b0;
			invert_select_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_PATTERN_LENGTH: begin
					pattern_length_q <= cfg_data[PATTERN_LEN_W-1:0];
				end
				CFG_PATTERN_WORD_A: begin
					pattern_word_q[0] <= cfg_data;
				end
				CFG_PATTERN_WORD_B: begin
					pattern_word_q[1] <= cfg_data;
				end
				CFG_PATTERN_WORD_C: begin
					pattern_word_q[2] <= cfg_data;
				end
				CFG_PATTERN_WORD_D: begin
					pattern_word_q[3] <= cfg_data;
				end
				CFG_FOLD_CASE: begin
					fold_case_q <= cfg_data[0];
				end
				CFG_INVERT_SELECT: begin
					invert_select_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Pattern bytes in order and the length clamped to the window size.
	assign pattern_all = {pattern_word_q[3], pattern_word_q[2], pattern_word_q[1],
		pattern_word_q[0]};
	assign match_len = (pattern_length_q > PATTERN_LEN_W'(PATTERN_MAX))
		? LEN_W'(PATTERN_MAX) : LEN_W'(pattern_length_q);

	// Input register; it moves on whenever the result register can take a word.
	assign advance = !(out_valid_q && out_stall);
	assign proc = in_valid_s1 && advance;
	assign in_stall = in_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// Decode what the word in the input register does.
	assign is_newline = (in_s1.text_byte == NEWLINE_CHAR);
	assign step.shift = proc && !in_s1.stream_end && !is_newline;
	assign step.line_close = proc && (in_s1.stream_end || is_newline);
	assign step.stream_end = proc && in_s1.stream_end;

	lfsm_window #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_window (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.text_byte(in_s1.text_byte),
		.pattern(pattern_all[PAT_BITS-1:0]),
		.match_len(match_len),
		.fold_case(fold_case_q),
		.byte_hit(byte_hit)
	);

	lfsm_line_ctrl u_line_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.byte_hit(byte_hit),
		.len_zero(match_len == '0),
		.invert_select(invert_select_q),
		.result(result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step.line_close) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.line_close) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef SYNTHESIS
	// The input side only stalls behind a held result word.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled result word");

	// A new result word only follows a closed line or an end marker.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(step.line_close))
		else $error("result word without a line close");

	// The end marker yields a result word flagged as stream done.
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		step.stream_end |=> (out_valid && out_data.stream_done))
		else $error("end marker lost its result word");
`endif

endmodule

`default_nettype wire
